[rtl/core/neighbour_table_aging_macros.svh]
// Assertion macros shared by the neighbour table checkers.
// Each macro expects a clock named i_clk and an active-low reset named i_rst_n in scope.
`ifndef NEIGHBOUR_TABLE_AGING_MACROS_SVH
`define NEIGHBOUR_TABLE_AGING_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define NTA_ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("neighbour table assertion failed");

// Consequent must hold in the cycle after the antecedent.
`define NTA_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("neighbour table assertion failed");

`endif

[rtl/core/nta_pkg.sv]
// Shared constants and types for the neighbour table with aging.
// Used by the channel interfaces, the top level and its checker.
package nta_pkg;

    localparam int TABLE_DEPTH = 12;
    localparam int IDX_W       = $clog2(TABLE_DEPTH);
    localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);

    localparam int KEY_W   = 32;
    localparam int TIME_W  = 32;
    localparam int HEARD_W = 4;
    localparam int SLOT_W  = 4;

    localparam int HEARD_MAX   = (1 << HEARD_W) - 1;
    localparam int HEARD_LIMIT = (TABLE_DEPTH < HEARD_MAX) ? TABLE_DEPTH : HEARD_MAX;

    // Fifteen minutes in milliseconds.
    localparam logic [TIME_W-1:0] WINDOW_RESET_MS = TIME_W'(15 * 60 * 1000);

    localparam logic OP_NOTE  = 1'b0;
    localparam logic OP_QUERY = 1'b1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_OLDEST,
        ST_WRITE,
        ST_DONE
    } t_state;

endpackage

[rtl/core/nta_ifs.sv]
// Valid/ready channel interfaces for the neighbour table: note/query beats in,
// count results out. Depends on nta_pkg.
interface nta_in_if;
    import nta_pkg::*;

    logic              valid;
    logic              ready;
    logic              op;
    logic [KEY_W-1:0]  node_prefix;
    logic [TIME_W-1:0] now_ms;

    modport source (output valid, output op, output node_prefix, output now_ms, input ready);
    modport sink   (input valid, input op, input node_prefix, input now_ms, output ready);
endinterface

interface nta_out_if;
    import nta_pkg::*;

    logic               valid;
    logic               ready;
    logic [HEARD_W-1:0] heard_count;
    logic               was_known;
    logic [SLOT_W-1:0]  slot_used;

    modport source (output valid, output heard_count, output was_known, output slot_used,
                    input ready);
    modport sink   (input valid, input heard_count, input was_known, input slot_used,
                    output ready);
endinterface

[rtl/core/neighbour_table_aging.sv]
// Neighbour table with aging: a walk over the entries with one shared
// elapsed-time subtract and window compare. Depends on nta_pkg and nta_ifs.
//
//  port      dir   beat contents
//  i_in      in    op, node_prefix, now_ms
//  o_out     out   heard_count, was_known, slot_used
//  i_cfg_*   in    window_ms (single register, write only)
//
// A query walks the entries once; a note walks them once and then writes, and a note
// that finds no match and no free or stale entry first makes a second walk that looks
// for the oldest entry. The result then waits in place until taken; a new beat is
// accepted the cycle after. Reset is synchronous and empties the table through one
// valid bit per entry.
module neighbour_table_aging (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    nta_in_if.sink                    i_in,
    nta_out_if.source                 o_out,
    input  logic                      i_cfg_wr_en,
    input  logic [nta_pkg::TIME_W-1:0] i_cfg_wr_data
);
    import nta_pkg::*;

    t_state r_state, n_state;

    logic [IDX_W-1:0]  r_idx, n_idx;
    logic              r_op, n_op;
    logic [KEY_W-1:0]  r_key, n_key;
    logic [TIME_W-1:0] r_now, n_now;
    logic [TIME_W-1:0] r_window;

    logic              r_hit, n_hit;
    logic              r_free, n_free;
    logic              r_known, n_known;
    logic [IDX_W-1:0]  r_slot, n_slot;
    logic [TIME_W-1:0] r_min, n_min;
    logic [CNT_W-1:0]  r_cnt, n_cnt;
    logic [TABLE_DEPTH-1:0] r_within, n_within;

    logic [TABLE_DEPTH-1:0] r_vld;
    logic [TIME_W-1:0]      r_etime [TABLE_DEPTH];
    logic [KEY_W-1:0]       r_ekey  [TABLE_DEPTH];

    // Shared per-entry unit.
    logic [TIME_W-1:0] cur_time;
    logic [TIME_W-1:0] elapsed;
    logic              cur_full;
    logic              cur_stale;
    logic              cur_hit;
    logic              cur_free;
    logic              cur_within;
    logic              last_idx;

    assign cur_time   = r_vld[r_idx] ? r_etime[r_idx] : '0;
    assign elapsed    = r_now - cur_time;
    assign cur_full   = (cur_time != '0);
    assign cur_stale  = (elapsed > r_window);
    assign cur_hit    = cur_full && (r_ekey[r_idx] == r_key);
    assign cur_free   = !cur_full || cur_stale;
    assign cur_within = cur_full && !cur_stale;
    assign last_idx   = (r_idx == IDX_W'(TABLE_DEPTH - 1));

    assign i_in.ready        = (r_state == ST_IDLE);
    assign o_out.valid       = (r_state == ST_DONE);
    assign o_out.heard_count = (32'(r_cnt) > HEARD_MAX) ? HEARD_W'(HEARD_MAX)
                                                        : HEARD_W'(r_cnt);
    assign o_out.was_known   = r_known;
    assign o_out.slot_used   = SLOT_W'(r_slot);

    always_comb begin
        n_state  = r_state;
        n_idx    = r_idx;
        n_op     = r_op;
        n_key    = r_key;
        n_now    = r_now;
        n_hit    = r_hit;
        n_free   = r_free;
        n_known  = r_known;
        n_slot   = r_slot;
        n_min    = r_min;
        n_cnt    = r_cnt;
        n_within = r_within;

        unique case (r_state)
            ST_IDLE: begin
                if (i_in.valid) begin
                    n_op    = i_in.op;
                    n_key   = i_in.node_prefix;
                    n_now   = i_in.now_ms;
                    n_idx   = '0;
                    n_hit   = 1'b0;
                    n_free  = 1'b0;
                    n_known = 1'b0;
                    n_slot  = '0;
                    n_cnt   = '0;
                    n_state = ST_SCAN;
                end
            end
            ST_SCAN: begin
                n_within[r_idx] = cur_within;
                if (cur_within) begin
                    n_cnt = r_cnt + CNT_W'(1);
                end
                // A match always wins; the first free entry is kept only until one shows up.
                if (r_op == OP_NOTE && !r_hit) begin
                    if (cur_hit) begin
                        n_hit  = 1'b1;
                        n_slot = r_idx;
                    end else if (!r_free && cur_free) begin
                        n_free = 1'b1;
                        n_slot = r_idx;
                    end
                end
                n_idx = r_idx + IDX_W'(1);
                if (last_idx) begin
                    n_idx = '0;
                    if (r_op == OP_QUERY) begin
                        n_state = ST_DONE;
                    end else if (n_hit || n_free) begin
                        n_state = ST_WRITE;
                    end else begin
                        n_state = ST_OLDEST;
                    end
                end
            end
            ST_OLDEST: begin
                if (r_idx == '0 || cur_time < r_min) begin
                    n_min  = cur_time;
                    n_slot = r_idx;
                end
                n_idx = r_idx + IDX_W'(1);
                if (last_idx) begin
                    n_idx   = '0;
                    n_state = ST_WRITE;
                end
            end
            ST_WRITE: begin
                // The replaced entry leaves the count; the new one joins unless stamped zero.
                n_cnt   = r_cnt - CNT_W'(r_within[r_slot]) + CNT_W'(r_now != '0);
                n_known = r_hit;
                n_state = ST_DONE;
            end
            ST_DONE: begin
                if (o_out.ready) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        r_idx    <= n_idx;
        r_op     <= n_op;
        r_key    <= n_key;
        r_now    <= n_now;
        r_hit    <= n_hit;
        r_free   <= n_free;
        r_known  <= n_known;
        r_slot   <= n_slot;
        r_min    <= n_min;
        r_cnt    <= n_cnt;
        r_within <= n_within;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_window <= WINDOW_RESET_MS;
        end else if (i_cfg_wr_en) begin
            r_window <= i_cfg_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (r_state == ST_WRITE) begin
            r_vld[r_slot] <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == ST_WRITE) begin
            r_etime[r_slot] <= r_now;
            r_ekey[r_slot]  <= r_key;
        end
    end

endmodule

[rtl/core/nta_checker.sv]
// Port-level checker for the neighbour table, bound to the top level.
// Depends on nta_pkg and neighbour_table_aging_macros.svh.
`include "neighbour_table_aging_macros.svh"

module nta_checker (
    input logic                         i_clk,
    input logic                         i_rst_n,
    input logic                         i_in_valid,
    input logic                         i_in_ready,
    input logic                         i_in_op,
    input logic                         i_out_valid,
    input logic                         i_out_ready,
    input logic [nta_pkg::HEARD_W-1:0]  i_heard_count,
    input logic                         i_was_known,
    input logic [nta_pkg::SLOT_W-1:0]   i_slot_used
);
    import nta_pkg::*;

    logic r_op;

    // Remember what kind of beat the pending result belongs to.
    always_ff @(posedge i_clk) begin
        if (i_in_valid && i_in_ready) begin
            r_op <= i_in_op;
        end
    end

    `NTA_ASSERT_NEXT(a_out_hold, i_out_valid && !i_out_ready, i_out_valid && $stable(i_heard_count) && $stable(i_was_known) && $stable(i_slot_used))
    `NTA_ASSERT_SAME(a_one_at_a_time, i_out_valid, !i_in_ready)
    `NTA_ASSERT_SAME(a_query_clean, i_out_valid && r_op == OP_QUERY, !i_was_known && i_slot_used == '0)
    `NTA_ASSERT_SAME(a_ranges, i_out_valid, 32'(i_heard_count) <= HEARD_LIMIT && 32'(i_slot_used) < TABLE_DEPTH)

endmodule

bind neighbour_table_aging nta_checker u_nta_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_in_valid    (i_in.valid),
    .i_in_ready    (i_in.ready),
    .i_in_op       (i_in.op),
    .i_out_valid   (o_out.valid),
    .i_out_ready   (o_out.ready),
    .i_heard_count (o_out.heard_count),
    .i_was_known   (o_out.was_known),
    .i_slot_used   (o_out.slot_used)
);

[tb/neighbour_table_aging_checker.sv]
`timescale 1ns / 100ps
// Checker for the neighbour table: watches the note/query and result channels and the
// window register port, predicts every result and compares it with what comes out.
// Depends on nta_pkg and the channel interfaces of nta_ifs.
module neighbour_table_aging_checker (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    nta_in_if                          i_in_mon,
    nta_out_if                         i_out_mon,
    input  logic                       i_cfg_wr_en,
    input  logic [nta_pkg::TIME_W-1:0] i_cfg_wr_data,
    output int                         o_mismatches,
    output int                         o_pending
);
    import nta_pkg::*;

    typedef struct packed {
        logic [HEARD_W-1:0] heard_count;
        logic               was_known;
        logic [SLOT_W-1:0]  slot_used;
    } t_heard_result;

    logic [KEY_W-1:0]  node_key   [TABLE_DEPTH];
    logic [TIME_W-1:0] node_stamp [TABLE_DEPTH];
    logic [TIME_W-1:0] heard_window;
    t_heard_result     expected_counts [$];

    // Applies one beat to the table copy and returns the result it should produce.
    function automatic t_heard_result note_and_count(input logic op,
                                                     input logic [KEY_W-1:0] key,
                                                     input logic [TIME_W-1:0] now);
        t_heard_result     res;
        logic [TIME_W-1:0] age;
        logic              matched;
        logic              have_free;
        int                slot;
        int                heard;
        res       = '0;
        matched   = 1'b0;
        have_free = 1'b0;
        slot      = 0;
        heard     = 0;
        if (op == OP_NOTE) begin
            for (int i = 0; i < TABLE_DEPTH; i++) begin
                age = now - node_stamp[i];
                if (!matched) begin
                    if (node_stamp[i] != '0 && node_key[i] == key) begin
                        matched = 1'b1;
                        slot    = i;
                    end else if (!have_free && (node_stamp[i] == '0 || age > heard_window)) begin
                        have_free = 1'b1;
                        slot      = i;
                    end
                end
            end
            // Full table with nothing stale: the smallest raw stamp goes, lowest index first.
            if (!matched && !have_free) begin
                slot = 0;
                for (int i = 1; i < TABLE_DEPTH; i++) begin
                    if (node_stamp[i] < node_stamp[slot])
                        slot = i;
                end
            end
            if (!matched)
                node_key[slot] = key;
            node_stamp[slot] = now;
            res.was_known    = matched;
            res.slot_used    = SLOT_W'(slot);
        end
        for (int i = 0; i < TABLE_DEPTH; i++) begin
            age = now - node_stamp[i];
            if (node_stamp[i] != '0 && age <= heard_window)
                heard++;
        end
        res.heard_count = HEARD_W'((heard > HEARD_MAX) ? HEARD_MAX : heard);
        return res;
    endfunction

    always @(posedge i_clk) begin : watch
        t_heard_result got;
        t_heard_result want;
        if (!i_rst_n) begin
            for (int i = 0; i < TABLE_DEPTH; i++) begin
                node_key[i]   = '0;
                node_stamp[i] = '0;
            end
            heard_window = WINDOW_RESET_MS;
            expected_counts.delete();
        end else begin
            if (i_cfg_wr_en === 1'b1)
                heard_window = i_cfg_wr_data;
            // Results are taken before new beats so a stray result never meets a fresh entry.
            if (i_out_mon.valid === 1'b1 && i_out_mon.ready === 1'b1) begin
                got.heard_count = i_out_mon.heard_count;
                got.was_known   = i_out_mon.was_known;
                got.slot_used   = i_out_mon.slot_used;
                if (expected_counts.size() == 0) begin
                    o_mismatches++;
                    if (o_mismatches <= 10)
                        $display("%0t: result beat with none expected: count %0d known %0b slot %0d",
                                 $time, got.heard_count, got.was_known, got.slot_used);
                end else begin
                    want = expected_counts.pop_front();
                    if (got.heard_count !== want.heard_count || got.was_known !== want.was_known
                        || got.slot_used !== want.slot_used) begin
                        o_mismatches++;
                        if (o_mismatches <= 10)
                            $display({"%0t: mismatch: expected count %0d known %0b slot %0d, ",
                                      "got count %0d known %0b slot %0d"}, $time,
                                     want.heard_count, want.was_known, want.slot_used,
                                     got.heard_count, got.was_known, got.slot_used);
                    end
                end
            end
            if (i_in_mon.valid === 1'b1 && i_in_mon.ready === 1'b1)
                expected_counts.push_back(note_and_count(i_in_mon.op, i_in_mon.node_prefix,
                                                         i_in_mon.now_ms));
        end
        o_pending <= expected_counts.size();
    end

endmodule

[tb/neighbour_table_aging_tb.sv]
`timescale 1ns / 100ps
// Testbench top for neighbour_table_aging: drives note and query beats and the window
// register, stalls the result side at random and prints the verdict from the checker.
// Depends on nta_pkg, nta_ifs, neighbour_table_aging and neighbour_table_aging_checker.
module neighbour_table_aging_tb;
    import nta_pkg::*;

    logic              clk = 1'b0;
    logic              rst_n;
    logic              cfg_wr_en;
    logic [TIME_W-1:0] cfg_wr_data;
    int                mismatches;
    int                pending;
    bit                send_steady;

    nta_in_if  in_ch ();
    nta_out_if out_ch ();

    always #5 clk = ~clk;

    neighbour_table_aging i_dut (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_in         (in_ch),
        .o_out        (out_ch),
        .i_cfg_wr_en  (cfg_wr_en),
        .i_cfg_wr_data(cfg_wr_data)
    );

    neighbour_table_aging_checker i_check (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_in_mon     (in_ch),
        .i_out_mon    (out_ch),
        .i_cfg_wr_en  (cfg_wr_en),
        .i_cfg_wr_data(cfg_wr_data),
        .o_mismatches (mismatches),
        .o_pending    (pending)
    );

    initial begin : watchdog
        #5_000_000;
        $display("CHECK FAILED");
        $finish;
    end

    // Result side: a random stall before each beat, calm stretches, and one long hold-off
    // that lets the block back up into its input.
    initial begin : result_sink
        int stall;
        int taken;
        bit steady;
        taken  = 0;
        steady = 1'b0;
        out_ch.ready <= 1'b0;
        forever begin
            if (taken % 40 == 0)
                steady = ($urandom_range(0, 3) == 0);
            if (taken == 250)
                stall = 400;
            else
                stall = steady ? 0 : $urandom_range(0, 13);
            if (stall > 0) begin
                out_ch.ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            out_ch.ready <= 1'b1;
            do @(posedge clk); while (out_ch.valid !== 1'b1);
            taken++;
        end
    end

    task automatic send_item(input logic op, input logic [KEY_W-1:0] key,
                             input logic [TIME_W-1:0] now);
        int gap;
        gap = send_steady ? 0 : $urandom_range(0, 13);
        if (gap > 0) begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_ch.valid       <= 1'b1;
        in_ch.op          <= op;
        in_ch.node_prefix <= key;
        in_ch.now_ms      <= now;
        do @(posedge clk); while (in_ch.ready !== 1'b1);
    endtask

    task automatic wait_idle();
        in_ch.valid <= 1'b0;
        do @(posedge clk); while (pending != 0);
    endtask

    task automatic write_window(input logic [TIME_W-1:0] value);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
    endtask

    // A pool of keys slightly larger than the table keeps matches, fills and evictions
    // common; clock steps are scaled to the window so stale entries come and go.
    task automatic run_phase(input logic [TIME_W-1:0] window, input int n_items);
        logic [KEY_W-1:0]  pool [16];
        logic [TIME_W-1:0] clock_ms;
        logic [TIME_W-1:0] now;
        logic [KEY_W-1:0]  key;
        logic              op;
        int                pick;
        wait_idle();
        write_window(window);
        foreach (pool[k])
            pool[k] = $urandom;
        if ($urandom_range(0, 2) == 0)
            clock_ms = 32'hFFFF_FFFF - $urandom_range(0, 4000);
        else
            clock_ms = $urandom;
        for (int n = 0; n < n_items; n++) begin
            if (n % 50 == 0)
                send_steady = ($urandom_range(0, 3) == 0);
            pick = $urandom_range(0, 99);
            if (pick < 55)
                clock_ms += $urandom_range(0, window / 8 + 2);
            else if (pick >= 70 && pick < 90)
                clock_ms += window - 1 + $urandom_range(0, 2);
            else if (pick >= 90)
                clock_ms += $urandom;
            now = ($urandom_range(0, 39) == 0) ? '0 : clock_ms;
            op  = ($urandom_range(0, 4) == 0) ? OP_QUERY : OP_NOTE;
            key = ($urandom_range(0, 9) == 0) ? $urandom : pool[$urandom_range(0, 15)];
            send_item(op, key, now);
        end
        send_steady = 1'b0;
    endtask

    initial begin : stimulus
        rst_n             <= 1'b0;
        cfg_wr_en         <= 1'b0;
        cfg_wr_data       <= '0;
        in_ch.valid       <= 1'b0;
        in_ch.op          <= OP_NOTE;
        in_ch.node_prefix <= '0;
        in_ch.now_ms      <= '0;
        send_steady = 1'b0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        // Directed part, at the reset window.
        send_item(OP_QUERY, '1, 32'd1000);
        // A note at time zero leaves its entry looking empty, so it is reused.
        send_item(OP_NOTE, 32'hAAAA_0001, '0);
        send_item(OP_NOTE, 32'hAAAA_0001, '0);
        send_item(OP_NOTE, '0, 32'd1);
        send_item(OP_NOTE, '0, 32'd2);
        send_item(OP_NOTE, '1, 32'd3);
        for (int i = 0; i < 10; i++)
            send_item(OP_NOTE, 32'h1000 + i, 32'd10 + i);
        // Table full and nothing stale: the oldest stamp is replaced.
        send_item(OP_NOTE, 32'h5555_AAAA, 32'd20);
        send_item(OP_QUERY, '1, '1);
        // Elapsed time equal to the window still counts as heard.
        send_item(OP_NOTE, 32'h1234_5678, 32'd900003);
        send_item(OP_NOTE, 32'h0000_0009, 32'd900004);
        send_item(OP_NOTE, 32'h0000_ABCD, 32'd900016);
        send_item(OP_QUERY, '0, 32'd900016);

        run_phase(32'd1, 165);
        run_phase('0, 165);
        run_phase('1, 165);
        run_phase(32'd1000, 165);
        run_phase($urandom_range(2, 5_000_000), 165);
        run_phase(WINDOW_RESET_MS, 165);

        wait_idle();
        repeat (30) @(posedge clk);
        if (mismatches == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
